// ----- hdl/mdcf_pkg.sv -----
// Shared types and constants for the message duplicate filter.
// Used by message_dedup_cooldown_filter; no dependencies.
package mdcf_pkg;

    localparam int HASH_W = 32;
    localparam int TIME_W = 47;
    localparam int CFG_W  = 16;
    localparam int BYTE_W = 8;
    localparam int ENTRY_W = HASH_W + TIME_W;

    localparam logic [HASH_W-1:0] HASH_INIT   = 32'd5381;
    localparam logic [5:0]        HASH_MULT   = 6'd33;
    localparam logic [9:0]        MS_PER_S    = 10'd1000;
    localparam logic [BYTE_W-1:0] CHAR_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_END    = 8'h00;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,  // no ')' yet
        PH_PAREN = 2'd1,  // first ')' was the previous byte
        PH_AFTER = 2'd2,  // ") " seen, hashing the tail
        PH_WHOLE = 2'd3   // ')' not followed by a space
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_COMMIT = 2'd2
    } state_t;

    function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] h,
                                              input logic [BYTE_W-1:0] c);
        logic [HASH_W-1:0] prod;
        prod = HASH_W'(h * HASH_W'(HASH_MULT));
        mix  = prod ^ HASH_W'(c);
    endfunction

endpackage

// ----- hdl/message_dedup_cooldown_filter.sv -----
// Message duplicate filter: running djb2 (xor) hashes and a slot table with cooldown.
// Non-zero bytes: one per cycle. Terminator: starts a table search, one RAM read per
// cycle, that ends at the first matching slot or after the last slot; the result then
// waits for a free output. Input is stalled during the table search and until the result is issued.
// Reset: asynchronous; hashes to 5381, cooldown to 0, slot valid bits cleared so the
// table reads as empty at once. Depends on mdcf_pkg and mdcf_ram.
module message_dedup_cooldown_filter #(
    parameter int SLOTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mdcf_pkg::CFG_W-1:0]    cooldown_seconds,
    // input request
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mdcf_pkg::BYTE_W-1:0]   msg_byte,
    input  logic [mdcf_pkg::TIME_W-1:0]   now_ms,
    // result
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send,
    output logic [mdcf_pkg::HASH_W-1:0]   msg_hash
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int DIFF_W = mdcf_pkg::TIME_W + 1;

    mdcf_pkg::state_t state_reg, state_next;
    mdcf_pkg::phase_t phase_reg, phase_next;

    logic [mdcf_pkg::CFG_W-1:0]  cooldown_reg;
    logic [mdcf_pkg::HASH_W-1:0] hash_whole_reg, hash_whole_next;
    logic [mdcf_pkg::HASH_W-1:0] hash_after_reg, hash_after_next;
    logic [mdcf_pkg::HASH_W-1:0] hsel_reg, hsel_next;
    logic [mdcf_pkg::TIME_W-1:0] now_reg, now_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic             eval_pending_reg, eval_pending_next;
    logic             eval_valid_reg, eval_valid_next;

    logic [IDX_W-1:0]            oldest_idx_reg, oldest_idx_next;
    logic [mdcf_pkg::TIME_W-1:0] oldest_time_reg, oldest_time_next;

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             do_write_reg, do_write_next;
    logic             send_dec_reg, send_dec_next;

    logic [SLOTS-1:0] slot_valid_reg, slot_valid_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          send_reg, send_next;
    logic [mdcf_pkg::HASH_W-1:0]   msg_hash_reg, msg_hash_next;

    // RAM interface
    logic                            ram_wr_en;
    logic [mdcf_pkg::ENTRY_W-1:0]    ram_rd_data;
    logic [mdcf_pkg::HASH_W-1:0]     entry_hash;
    logic [mdcf_pkg::TIME_W-1:0]     entry_time;

    logic              in_accept;
    logic              out_free;
    logic              hit;
    logic              too_soon;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] limit;

    mdcf_ram #(
        .WIDTH (mdcf_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data ({hsel_reg, now_reg}),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mdcf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_wr_en = (state_reg == mdcf_pkg::ST_COMMIT) && out_free && do_write_reg;

    // unwritten slots read as empty
    assign entry_hash = ram_rd_data[mdcf_pkg::ENTRY_W-1:mdcf_pkg::TIME_W];
    assign entry_time = eval_valid_reg ? ram_rd_data[mdcf_pkg::TIME_W-1:0]
                                       : '0;

    assign hit   = (entry_time != '0) && (entry_hash == hsel_reg);
    assign diff  = {1'b0, now_reg} - {1'b0, entry_time};
    assign limit = DIFF_W'(cooldown_reg) * DIFF_W'(mdcf_pkg::MS_PER_S);
    // time running backwards gives a negative difference and counts as too soon
    assign too_soon = $signed(diff) < $signed(limit);

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        hash_whole_next   = hash_whole_reg;
        hash_after_next   = hash_after_reg;
        hsel_next         = hsel_reg;
        now_next          = now_reg;
        scan_idx_next     = scan_idx_reg;
        issue_done_next   = issue_done_reg;
        eval_idx_next     = eval_idx_reg;
        eval_pending_next = 1'b0;
        eval_valid_next   = eval_valid_reg;
        oldest_idx_next   = oldest_idx_reg;
        oldest_time_next  = oldest_time_reg;
        wr_idx_next       = wr_idx_reg;
        do_write_next     = do_write_reg;
        send_dec_next     = send_dec_reg;
        slot_valid_next   = slot_valid_reg;
        out_valid_next    = out_valid_reg && out_stall;
        send_next         = send_reg;
        msg_hash_next     = msg_hash_reg;

        unique case (state_reg)
            mdcf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (msg_byte != mdcf_pkg::CHAR_END)
                    begin
                        hash_whole_next = mdcf_pkg::mix(hash_whole_reg, msg_byte);
                        unique case (phase_reg)
                            mdcf_pkg::PH_NONE:
                            begin
                                if (msg_byte == mdcf_pkg::CHAR_RPAREN)
                                begin
                                    phase_next = mdcf_pkg::PH_PAREN;
                                end
                            end
                            mdcf_pkg::PH_PAREN:
                            begin
                                phase_next = (msg_byte == mdcf_pkg::CHAR_SPACE)
                                           ? mdcf_pkg::PH_AFTER : mdcf_pkg::PH_WHOLE;
                            end
                            mdcf_pkg::PH_AFTER:
                            begin
                                hash_after_next = mdcf_pkg::mix(hash_after_reg, msg_byte);
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    else
                    begin
                        hsel_next = (phase_reg == mdcf_pkg::PH_AFTER) ? hash_after_reg
                                                                      : hash_whole_reg;
                        now_next        = now_ms;
                        hash_whole_next = mdcf_pkg::HASH_INIT;
                        hash_after_next = mdcf_pkg::HASH_INIT;
                        phase_next      = mdcf_pkg::PH_NONE;
                        scan_idx_next   = '0;
                        issue_done_next = 1'b0;
                        state_next      = mdcf_pkg::ST_SCAN;
                    end
                end
            end

            mdcf_pkg::ST_SCAN:
            begin
                // issue side: one read per cycle
                if (!issue_done_reg)
                begin
                    eval_pending_next = 1'b1;
                    eval_idx_next     = scan_idx_reg;
                    eval_valid_next   = slot_valid_reg[scan_idx_reg];
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end

                // compare side: entry read last cycle
                if (eval_pending_reg)
                begin
                    if (hit)
                    begin
                        wr_idx_next       = eval_idx_reg;
                        do_write_next     = !too_soon;
                        send_dec_next     = !too_soon;
                        eval_pending_next = 1'b0;
                        state_next        = mdcf_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        if ((eval_idx_reg == '0) || (entry_time < oldest_time_reg))
                        begin
                            oldest_idx_next  = eval_idx_reg;
                            oldest_time_next = entry_time;
                        end
                        if (eval_idx_reg == LAST_IDX)
                        begin
                            wr_idx_next = ((eval_idx_reg == '0)
                                           || (entry_time < oldest_time_reg))
                                        ? eval_idx_reg : oldest_idx_reg;
                            do_write_next     = 1'b1;
                            send_dec_next     = 1'b1;
                            eval_pending_next = 1'b0;
                            state_next        = mdcf_pkg::ST_COMMIT;
                        end
                    end
                end
            end

            mdcf_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    send_next      = send_dec_reg;
                    msg_hash_next  = hsel_reg;
                    if (do_write_reg)
                    begin
                        slot_valid_next[wr_idx_reg] = 1'b1;
                    end
                    state_next = mdcf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mdcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mdcf_pkg::ST_IDLE;
            phase_reg        <= mdcf_pkg::PH_NONE;
            cooldown_reg     <= '0;
            hash_whole_reg   <= mdcf_pkg::HASH_INIT;
            hash_after_reg   <= mdcf_pkg::HASH_INIT;
            scan_idx_reg     <= '0;
            issue_done_reg   <= 1'b0;
            eval_pending_reg <= 1'b0;
            slot_valid_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            hash_whole_reg   <= hash_whole_next;
            hash_after_reg   <= hash_after_next;
            scan_idx_reg     <= scan_idx_next;
            issue_done_reg   <= issue_done_next;
            eval_pending_reg <= eval_pending_next;
            slot_valid_reg   <= slot_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cooldown_reg <= cooldown_seconds;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hsel_reg        <= hsel_next;
        now_reg         <= now_next;
        eval_idx_reg    <= eval_idx_next;
        eval_valid_reg  <= eval_valid_next;
        oldest_idx_reg  <= oldest_idx_next;
        oldest_time_reg <= oldest_time_next;
        wr_idx_reg      <= wr_idx_next;
        do_write_reg    <= do_write_next;
        send_dec_reg    <= send_dec_next;
        send_reg        <= send_next;
        msg_hash_reg    <= msg_hash_next;
    end

    assign out_valid = out_valid_reg;
    assign send      = send_reg;
    assign msg_hash  = msg_hash_reg;

endmodule

// ----- hdl/mdcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mdcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
